// ===== rtl/core/pic8_pkg.sv =====
`timescale 1ns / 1ps

package pic8_pkg;

  // Operation carried by one input word
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ACK   = 2'd2,
    OP_TICK  = 2'd3
  } pic8_op_t;

  // Initialization sequencer, one-hot
  typedef enum logic [3:0] {
    PH_READY = 4'b0001,
    PH_W2    = 4'b0010,
    PH_W3    = 4'b0100,
    PH_W4    = 4'b1000
  } pic8_phase_t;

  // Command byte bits
  localparam int unsigned ICW1_SEL_BIT   = 4;
  localparam int unsigned ICW1_LEVEL_BIT = 3;
  localparam int unsigned ICW1_SNGL_BIT  = 1;
  localparam int unsigned ICW1_IC4_BIT   = 0;
  localparam int unsigned ICW4_X86_BIT   = 0;
  localparam int unsigned ICW4_AEOI_BIT  = 1;
  localparam int unsigned OCW3_RR_BIT    = 1;
  localparam int unsigned OCW3_RIS_BIT   = 0;

  // OCW kind in bits 4..3
  localparam logic [1:0] OCW_KIND_OCW2 = 2'b00;
  localparam logic [1:0] OCW_KIND_OCW3 = 2'b01;

  // OCW2 end-of-interrupt codes in bits 7..5
  localparam logic [2:0] EOI_NONSPEC     = 3'd1;
  localparam logic [2:0] EOI_SPEC        = 3'd3;
  localparam logic [2:0] EOI_ROT_NONSPEC = 3'd5;

  typedef struct packed {
    logic [1:0] opcode;
    logic       addr_bit;
    logic [7:0] write_byte;
    logic [7:0] request_lines;
  } pic8_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       bus_drive;
    logic       int_line;
  } pic8_result_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } pic8_prio_t;

  // Fixed priority: lowest set bit wins
  function automatic pic8_prio_t lowest_set(input logic [7:0] v);
    pic8_prio_t p;
    p.found = 1'b0;
    p.idx   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = 3'(i);
      end
    end
    return p;
  endfunction

  // Re-evaluate the interrupt output; hold it while not initialized
  function automatic logic eval_int(input logic rdy, input logic cur,
                                    input logic [7:0] req, input logic [7:0] msk,
                                    input logic [7:0] svc);
    pic8_prio_t r;
    pic8_prio_t s;
    r = lowest_set(req & ~msk);
    s = lowest_set(svc);
    if (!rdy) begin
      return cur;
    end
    return r.found && (!s.found || (r.idx < s.idx));
  endfunction

endpackage

// ===== rtl/core/pic8_if.sv =====
`timescale 1ns / 1ps

// Request channel
interface pic8_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       addr_bit;
  logic [7:0] write_byte;
  logic [7:0] request_lines;

  modport source (output valid, output opcode, output addr_bit, output write_byte,
                  output request_lines, input ready);
  modport sink   (input valid, input opcode, input addr_bit, input write_byte,
                  input request_lines, output ready);
endinterface

// Result channel
interface pic8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       bus_drive;
  logic       int_line;

  modport source (output valid, output bus_byte, output bus_drive, output int_line,
                  input ready);
  modport sink   (input valid, input bus_byte, input bus_drive, input int_line,
                  output ready);
endinterface

// ===== rtl/core/interrupt_controller_8level_top.sv =====
`timescale 1ns / 1ps

// Eight-level fixed-priority interrupt controller.
// in_ch carries one word per operation: a bus write, a bus read, one
// acknowledge pulse or a plain tick, each with a sample of the eight
// request lines. out_ch returns exactly one word per input word: the
// data bus byte, its drive flag and the interrupt line level after the
// operation.
// An accepted word is held in the input register, processed by the
// single-pass update logic, and its result is captured in the result
// register once that register is empty or being read out.
// One word is accepted and one result produced every cycle while out_ch
// does not stall; the rate is set by the single state update between the
// input and result registers.
// When out_ch stalls, the result register holds its word and the input
// register holds one more; in_ch.ready drops only when both are full.
// After reset (rst_n low at a clock edge) both registers are empty and the
// controller waits for ICW1; reads and acknowledges before initialization
// return an undriven bus.
module interrupt_controller_8level_top import pic8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pic8_in_if.sink     in_ch,
  pic8_out_if.source  out_ch
);

  logic         in_vld_r;
  pic8_item_t   in_item_r;
  logic         out_vld_r;
  pic8_result_t out_res_r;
  pic8_result_t step_res;
  logic         advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  pic8_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .result  (step_res)
  );

  // Track occupancy of input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.opcode        <= in_ch.opcode;
      in_item_r.addr_bit      <= in_ch.addr_bit;
      in_item_r.write_byte    <= in_ch.write_byte;
      in_item_r.request_lines <= in_ch.request_lines;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.bus_byte  = out_res_r.bus_byte;
  assign out_ch.bus_drive = out_res_r.bus_drive;
  assign out_ch.int_line  = out_res_r.int_line;

endmodule

// ===== rtl/core/pic8_engine.sv =====
`timescale 1ns / 1ps

module pic8_engine import pic8_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  pic8_item_t   item,
  output pic8_result_t result
);

  logic [7:0]  request_r, request_nxt;
  logic [7:0]  service_r, service_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [4:0]  vec_high_r, vec_high_nxt;
  logic        edge_mode_r, edge_mode_nxt;
  logic        single_r, single_nxt;
  logic        want_icw4_r, want_icw4_nxt;
  logic        aeoi_r, aeoi_nxt;
  logic        x86_r, x86_nxt;
  logic        show_isr_r, show_isr_nxt;
  pic8_phase_t phase_r, phase_nxt;
  logic        rdy_r, rdy_nxt;
  logic [1:0]  ack_cnt_r, ack_cnt_nxt;
  logic        ack_vld_r, ack_vld_nxt;
  logic [2:0]  ack_lvl_r, ack_lvl_nxt;
  logic [7:0]  lines_prev_r, lines_prev_nxt;
  logic        int_r, int_nxt;

  // Perform one operation, then sample the request lines
  always_comb begin
    logic [7:0] d;
    logic [7:0] lines;
    logic [7:0] req_pre;
    logic [7:0] rise;
    logic [2:0] code;
    pic8_prio_t p;

    d     = item.write_byte;
    lines = item.request_lines;

    request_nxt    = request_r;
    service_nxt    = service_r;
    mask_nxt       = mask_r;
    vec_high_nxt   = vec_high_r;
    edge_mode_nxt  = edge_mode_r;
    single_nxt     = single_r;
    want_icw4_nxt  = want_icw4_r;
    aeoi_nxt       = aeoi_r;
    x86_nxt        = x86_r;
    show_isr_nxt   = show_isr_r;
    phase_nxt      = phase_r;
    rdy_nxt        = rdy_r;
    ack_cnt_nxt    = ack_cnt_r;
    ack_vld_nxt    = ack_vld_r;
    ack_lvl_nxt    = ack_lvl_r;
    int_nxt        = int_r;
    result         = '0;
    code           = d[7:5];
    p              = '0;

    case (pic8_op_t'(item.opcode))
      OP_WRITE: begin
        if (!item.addr_bit && d[ICW1_SEL_BIT]) begin
          // ICW1 restarts initialization
          edge_mode_nxt = !d[ICW1_LEVEL_BIT];
          single_nxt    = d[ICW1_SNGL_BIT];
          want_icw4_nxt = d[ICW1_IC4_BIT];
          phase_nxt     = PH_W2;
          rdy_nxt       = 1'b0;
          mask_nxt      = '0;
          service_nxt   = '0;
          request_nxt   = '0;
          aeoi_nxt      = 1'b0;
          show_isr_nxt  = 1'b0;
          ack_cnt_nxt   = '0;
          ack_vld_nxt   = 1'b0;
          int_nxt       = 1'b0;
        end else if (item.addr_bit && phase_r == PH_W2) begin
          vec_high_nxt = d[7:3];
          if (!single_r) begin
            phase_nxt = PH_W3;
          end else if (want_icw4_r) begin
            phase_nxt = PH_W4;
          end else begin
            phase_nxt = PH_READY;
            rdy_nxt   = 1'b1;
            int_nxt   = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
          end
        end else if (item.addr_bit && phase_r == PH_W3) begin
          if (want_icw4_r) begin
            phase_nxt = PH_W4;
          end else begin
            phase_nxt = PH_READY;
            rdy_nxt   = 1'b1;
            int_nxt   = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
          end
        end else if (item.addr_bit && phase_r == PH_W4) begin
          x86_nxt  = d[ICW4_X86_BIT];
          aeoi_nxt = d[ICW4_AEOI_BIT];
          if (edge_mode_r) begin
            request_nxt = request_nxt | lines;
          end
          phase_nxt = PH_READY;
          rdy_nxt   = 1'b1;
          int_nxt   = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
        end else if (rdy_r) begin
          if (item.addr_bit) begin
            mask_nxt = d;
            int_nxt  = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
          end else if (d[4:3] == OCW_KIND_OCW2) begin
            // End of interrupt
            p = lowest_set(service_r);
            if (code inside {EOI_NONSPEC, EOI_ROT_NONSPEC}) begin
              if (p.found) begin
                service_nxt[p.idx] = 1'b0;
              end
            end else if (code == EOI_SPEC) begin
              service_nxt[d[2:0]] = 1'b0;
            end
            int_nxt = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
          end else if (d[4:3] == OCW_KIND_OCW3) begin
            if (d[OCW3_RR_BIT]) begin
              show_isr_nxt = d[OCW3_RIS_BIT];
            end
          end
        end
      end
      OP_READ: begin
        if (rdy_r) begin
          result.bus_byte  = item.addr_bit ? mask_r : (show_isr_r ? service_r : request_r);
          result.bus_drive = 1'b1;
        end
      end
      OP_ACK: begin
        if (rdy_r) begin
          if (ack_cnt_r + 2'd1 == 2'd1) begin
            // First pulse: latch the winning level
            ack_cnt_nxt = 2'd1;
            p = lowest_set(request_r & ~mask_r);
            ack_vld_nxt = p.found;
            ack_lvl_nxt = p.idx;
            if (p.found) begin
              service_nxt[p.idx] = 1'b1;
              request_nxt[p.idx] = 1'b0;
              int_nxt            = 1'b0;
            end
          end else begin
            // Second pulse: drive the vector
            if (ack_vld_r) begin
              result.bus_byte = x86_r ? {vec_high_r, ack_lvl_r}
                                      : ({vec_high_r, 3'b000} | {3'b000, ack_lvl_r, 2'b00});
              result.bus_drive = 1'b1;
              if (aeoi_r) begin
                service_nxt[ack_lvl_r] = 1'b0;
              end
            end
            int_nxt     = eval_int(1'b1, int_r, request_nxt, mask_nxt, service_nxt);
            ack_cnt_nxt = '0;
            ack_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // Sample request lines
    req_pre = request_nxt;
    rise    = lines & ~lines_prev_r;
    if (edge_mode_nxt) begin
      request_nxt = request_nxt | rise;
      if (rise != '0) begin
        int_nxt = eval_int(rdy_nxt, int_nxt, request_nxt, mask_nxt, service_nxt);
      end
    end else begin
      request_nxt = lines;
      if (lines != lines_prev_r || request_nxt != req_pre) begin
        int_nxt = eval_int(rdy_nxt, int_nxt, request_nxt, mask_nxt, service_nxt);
      end
    end
    lines_prev_nxt = lines;

    result.int_line = int_nxt;
  end

  // Commit state when a word is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_r    <= '0;
      service_r    <= '0;
      mask_r       <= '0;
      vec_high_r   <= '0;
      edge_mode_r  <= 1'b1;
      single_r     <= 1'b1;
      want_icw4_r  <= 1'b0;
      aeoi_r       <= 1'b0;
      x86_r        <= 1'b1;
      show_isr_r   <= 1'b0;
      phase_r      <= PH_READY;
      rdy_r        <= 1'b0;
      ack_cnt_r    <= '0;
      ack_vld_r    <= 1'b0;
      lines_prev_r <= '0;
      int_r        <= 1'b0;
    end else if (step_en) begin
      request_r    <= request_nxt;
      service_r    <= service_nxt;
      mask_r       <= mask_nxt;
      vec_high_r   <= vec_high_nxt;
      edge_mode_r  <= edge_mode_nxt;
      single_r     <= single_nxt;
      want_icw4_r  <= want_icw4_nxt;
      aeoi_r       <= aeoi_nxt;
      x86_r        <= x86_nxt;
      show_isr_r   <= show_isr_nxt;
      phase_r      <= phase_nxt;
      rdy_r        <= rdy_nxt;
      ack_cnt_r    <= ack_cnt_nxt;
      ack_vld_r    <= ack_vld_nxt;
      lines_prev_r <= lines_prev_nxt;
      int_r        <= int_nxt;
    end
  end

  // Latched level carries no reset; its valid bit guards it
  always_ff @(posedge clk) begin
    if (step_en) begin
      ack_lvl_r <= ack_lvl_nxt;
    end
  end

endmodule

// ===== tb/pic8_bus_checker.sv =====
`timescale 1ns / 1ps

module pic8_bus_checker import pic8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pic8_in_if          mon_in,
  pic8_out_if         mon_out,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int NO_LEVEL = 8;

  // Shadow copy of the controller state
  logic [7:0]  irr;
  logic [7:0]  isr;
  logic [7:0]  imr;
  logic [7:0]  lines_seen;
  logic [4:0]  vec_base;
  logic        edge_trig;
  logic        single;
  logic        need_icw4;
  logic        aeoi;
  logic        x86;
  logic        read_isr;
  logic        inited;
  logic        int_out;
  logic [1:0]  pulses;
  logic        latched;
  logic [2:0]  latched_lvl;
  pic8_phase_t phase;

  // Bus results owed by the controller, oldest first
  pic8_result_t due_results[$];
  int unsigned  err_count;

  // Highest priority is the lowest set bit
  function automatic int first_level(input logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        return i;
      end
    end
    return NO_LEVEL;
  endfunction

  task automatic reset_shadow();
    irr = '0; isr = '0; imr = '0; lines_seen = '0; vec_base = '0;
    edge_trig = 1'b1; single = 1'b1; need_icw4 = 1'b0; aeoi = 1'b0; x86 = 1'b1;
    read_isr = 1'b0; inited = 1'b0; int_out = 1'b0;
    pulses = '0; latched = 1'b0; latched_lvl = '0;
    phase = PH_READY;
  endtask

  // Re-evaluate INT: an unmasked request above every in-service level; hold while not ready
  task automatic update_int();
    int r;
    int s;
    if (!inited) begin
      return;
    end
    r = first_level(irr & ~imr);
    s = first_level(isr);
    int_out = (r != NO_LEVEL) && (r < s);
  endtask

  task automatic end_init();
    phase  = PH_READY;
    inited = 1'b1;
    update_int();
  endtask

  // Apply one bus write: init sequence first, then OCWs once ready
  task automatic bus_write(input logic a0, input logic [7:0] d, input logic [7:0] rl);
    int lvl;
    if (!a0 && d[ICW1_SEL_BIT]) begin
      edge_trig = !d[ICW1_LEVEL_BIT];
      single    = d[ICW1_SNGL_BIT];
      need_icw4 = d[ICW1_IC4_BIT];
      phase     = PH_W2;
      inited    = 1'b0;
      imr = '0; isr = '0; irr = '0;
      aeoi = 1'b0; read_isr = 1'b0;
      pulses = '0; latched = 1'b0; latched_lvl = '0;
      int_out = 1'b0;
    end else if (a0 && phase == PH_W2) begin
      vec_base = d[7:3];
      if (!single) begin
        phase = PH_W3;
      end else if (need_icw4) begin
        phase = PH_W4;
      end else begin
        end_init();
      end
    end else if (a0 && phase == PH_W3) begin
      if (need_icw4) begin
        phase = PH_W4;
      end else begin
        end_init();
      end
    end else if (a0 && phase == PH_W4) begin
      x86  = d[ICW4_X86_BIT];
      aeoi = d[ICW4_AEOI_BIT];
      // edge mode grabs every line already high
      if (edge_trig) begin
        irr = irr | rl;
      end
      end_init();
    end else if (inited) begin
      if (a0) begin
        imr = d;
        update_int();
      end else if (d[4:3] == OCW_KIND_OCW2) begin
        if (d[7:5] == EOI_NONSPEC || d[7:5] == EOI_ROT_NONSPEC) begin
          lvl = first_level(isr);
          if (lvl != NO_LEVEL) begin
            isr[lvl] = 1'b0;
          end
        end else if (d[7:5] == EOI_SPEC) begin
          isr[d[2:0]] = 1'b0;
        end
        update_int();
      end else if (d[4:3] == OCW_KIND_OCW3 && d[OCW3_RR_BIT]) begin
        read_isr = d[OCW3_RIS_BIT];
      end
    end
  endtask

  // Predict the bus result of one input word and advance the shadow state
  task automatic advance_controller(input pic8_item_t w, output pic8_result_t res);
    int         lvl;
    logic [7:0] irr_prev;
    logic [7:0] rise;
    res = '0;
    case (pic8_op_t'(w.opcode))
      OP_WRITE: begin
        bus_write(w.addr_bit, w.write_byte, w.request_lines);
      end
      OP_READ: begin
        if (inited) begin
          res.bus_byte  = w.addr_bit ? imr : (read_isr ? isr : irr);
          res.bus_drive = 1'b1;
        end
      end
      OP_ACK: begin
        if (inited) begin
          pulses = pulses + 2'd1;
          if (pulses == 2'd1) begin
            // first pulse: latch the winning level
            lvl         = first_level(irr & ~imr);
            latched     = (lvl != NO_LEVEL);
            latched_lvl = 3'(lvl);
            if (latched) begin
              isr[lvl] = 1'b1;
              irr[lvl] = 1'b0;
              int_out  = 1'b0;
            end
          end else begin
            // second pulse: drive the vector
            if (latched) begin
              res.bus_byte  = x86 ? {vec_base, latched_lvl}
                                  : ({vec_base, 3'b000} | {3'b000, latched_lvl, 2'b00});
              res.bus_drive = 1'b1;
              if (aeoi) begin
                isr[latched_lvl] = 1'b0;
              end
            end
            update_int();
            pulses      = '0;
            latched     = 1'b0;
            latched_lvl = '0;
          end
        end
      end
      default: begin
      end
    endcase

    // Sample the request lines
    irr_prev = irr;
    rise     = w.request_lines & ~lines_seen;
    if (edge_trig) begin
      irr = irr | rise;
      if (rise != 8'd0) begin
        update_int();
      end
    end else begin
      irr = w.request_lines;
      if (w.request_lines != lines_seen || irr != irr_prev) begin
        update_int();
      end
    end
    lines_seen   = w.request_lines;
    res.int_line = int_out;
  endtask

  // Compare finished words first, then predict newly accepted ones
  always @(posedge clk) begin
    pic8_item_t   word;
    pic8_result_t want;
    pic8_result_t got;
    if (!rst_n) begin
      reset_shadow();
      due_results.delete();
      err_count = 0;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        got.bus_byte  = mon_out.bus_byte;
        got.bus_drive = mon_out.bus_drive;
        got.int_line  = mon_out.int_line;
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result word: byte %02h drive %0b int %0b",
                     got.bus_byte, got.bus_drive, got.int_line);
          end
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: expected byte %02h drive %0b int %0b, got byte %02h drive %0b int %0b",
                       want.bus_byte, want.bus_drive, want.int_line,
                       got.bus_byte, got.bus_drive, got.int_line);
            end
          end
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        word.opcode        = mon_in.opcode;
        word.addr_bit      = mon_in.addr_bit;
        word.write_byte    = mon_in.write_byte;
        word.request_lines = mon_in.request_lines;
        advance_controller(word, want);
        due_results.push_back(want);
      end
    end
    mismatches  <= err_count;
    outstanding <= due_results.size();
  end

endmodule

// ===== tb/tb_interrupt_controller_8level_top.sv =====
`timescale 1ns / 1ps

module tb_interrupt_controller_8level_top;
  import pic8_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned words_sent;
  logic [7:0]  lines;

  pic8_in_if  in_ch ();
  pic8_out_if out_ch ();

  interrupt_controller_8level_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pic8_bus_checker bus_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .mon_in      (in_ch),
    .mon_out     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Hand one word over; called and returns at a falling edge
  task automatic send_word(input pic8_op_t op, input logic a0, input logic [7:0] d,
                           input logic [7:0] rl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.addr_bit      <= a0;
    in_ch.write_byte    <= d;
    in_ch.request_lines <= rl;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    words_sent++;
  endtask

  // Jitter the request lines so edges land on every kind of operation
  task automatic issue(input pic8_op_t op, input logic a0, input logic [7:0] d);
    if ($urandom_range(99) < 35) begin
      lines = lines ^ (8'h01 << $urandom_range(7));
    end else if ($urandom_range(99) < 5) begin
      lines = 8'($urandom);
    end
    send_word(op, a0, d, lines);
  endtask

  // Init sequence with random mode bits, sometimes broken off or interleaved
  task automatic random_init();
    logic [7:0] icw1;
    icw1 = 8'($urandom);
    icw1[ICW1_SEL_BIT] = 1'b1;
    issue(OP_WRITE, 1'b0, icw1);
    if ($urandom_range(99) < 8) begin
      return;
    end
    if ($urandom_range(99) < 10) begin
      issue(pic8_op_t'($urandom_range(3)), 1'($urandom), 8'($urandom));
    end
    issue(OP_WRITE, 1'b1, 8'($urandom));
    if (!icw1[ICW1_SNGL_BIT]) begin
      issue(OP_WRITE, 1'b1, 8'($urandom));
    end
    if (icw1[ICW1_IC4_BIT]) begin
      issue(OP_WRITE, 1'b1, 8'($urandom));
    end
  endtask

  // Mix of acknowledge cycles, reads, masks and OCWs, normally on an initialized controller
  task automatic random_body(input int unsigned n);
    int unsigned pick;
    logic [7:0]  d;
    repeat (n) begin
      pick = $urandom_range(99);
      d    = 8'($urandom);
      if (pick < 22) begin
        issue(OP_ACK, 1'($urandom), d);
        repeat ($urandom_range(2)) begin
          issue(OP_TICK, 1'($urandom), 8'($urandom));
        end
        issue(OP_ACK, 1'($urandom), 8'($urandom));
      end else if (pick < 26) begin
        issue(OP_ACK, 1'($urandom), d);
      end else if (pick < 42) begin
        issue(OP_READ, 1'($urandom), d);
      end else if (pick < 52) begin
        // favor sparse masks so requests get through
        if ($urandom_range(1) == 1) begin
          d = d & 8'($urandom) & 8'($urandom);
        end
        issue(OP_WRITE, 1'b1, d);
      end else if (pick < 66) begin
        d[4:3] = OCW_KIND_OCW2;
        case ($urandom_range(3))
          0: d[7:5] = EOI_NONSPEC;
          1: d[7:5] = EOI_SPEC;
          2: d[7:5] = EOI_ROT_NONSPEC;
          default: begin
          end
        endcase
        issue(OP_WRITE, 1'b0, d);
      end else if (pick < 74) begin
        d[4:3] = OCW_KIND_OCW3;
        issue(OP_WRITE, 1'b0, d);
      end else if (pick < 76) begin
        issue(OP_WRITE, 1'($urandom), d);
      end else begin
        issue(OP_TICK, 1'($urandom), d);
      end
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned sink_pct,
                           input int unsigned upto);
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    while (words_sent < upto) begin
      random_init();
      random_body($urandom_range(60, 15));
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.addr_bit      = 1'b0;
    in_ch.write_byte    = '0;
    in_ch.request_lines = '0;
    out_ch.ready        = 1'b0;
    lines               = '0;
    words_sent          = 0;
    send_idle_pct       = 24;
    sink_idle_pct       = 59;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bus accesses before initialization are ignored
    send_word(OP_READ,  1'b0, 8'h00, 8'h00);
    send_word(OP_ACK,   1'b0, 8'h00, 8'h00);
    send_word(OP_WRITE, 1'b1, 8'hFF, 8'hFF);
    // ICW1 restarts a sequence already under way
    send_word(OP_WRITE, 1'b0, 8'h13, 8'h00);
    send_word(OP_WRITE, 1'b1, 8'h20, 8'h00);
    send_word(OP_WRITE, 1'b0, 8'h11, 8'h00);
    // Cascade with ICW4: 8080 spacing, lines high at ICW4 get latched
    send_word(OP_WRITE, 1'b1, 8'hFF, 8'h00);
    send_word(OP_WRITE, 1'b1, 8'h00, 8'h00);
    send_word(OP_WRITE, 1'b1, 8'h00, 8'hA5);
    send_word(OP_READ,  1'b0, 8'h00, 8'hA5);
    send_word(OP_WRITE, 1'b0, 8'h0B, 8'hA5);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hA5);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hA5);
    send_word(OP_READ,  1'b0, 8'h00, 8'hA5);
    send_word(OP_WRITE, 1'b0, 8'h20, 8'hA5);
    // All masked: acknowledge finds nothing pending
    send_word(OP_WRITE, 1'b1, 8'hFF, 8'hA5);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hA5);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hA5);
    send_word(OP_READ,  1'b1, 8'h00, 8'hA5);
    send_word(OP_WRITE, 1'b1, 8'h00, 8'h00);
    // Specific, rotating and no-op EOI codes; OCW3 with poll and special mask
    send_word(OP_WRITE, 1'b0, 8'h67, 8'h00);
    send_word(OP_WRITE, 1'b0, 8'hA0, 8'h00);
    send_word(OP_WRITE, 1'b0, 8'h40, 8'h00);
    send_word(OP_WRITE, 1'b0, 8'h6C, 8'h00);
    // Level mode, x86 vectors with auto EOI
    send_word(OP_WRITE, 1'b0, 8'h1B, 8'hFF);
    send_word(OP_WRITE, 1'b1, 8'hFF, 8'hFF);
    send_word(OP_WRITE, 1'b1, 8'h03, 8'hFF);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hFF);
    send_word(OP_ACK,   1'b0, 8'h00, 8'hFF);
    send_word(OP_TICK,  1'b1, 8'hFF, 8'h00);

    run_phase(24, 59, 470);
    run_phase(59, 24, 940);
    run_phase(0, 0, 1400);
    in_ch.valid <= 1'b0;

    // Drain the results, then allow for any stray word
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
